// ----- src/pfla_pkg.sv -----
package pfla_pkg;

  // Fraction bits of the fixed-point camera and step values
  localparam int FRACTION_BITS_DEF = 8;

  // Floor distance numerator and texel center
  localparam int FLOOR_DISTANCE = 160;
  localparam int DISTANCE_BITS  = 8;
  localparam int TEXEL_CENTER   = 128;

  // Divider: restoring steps resolved in one pipeline stage
  localparam int DIV_STEPS_PER_STAGE = 4;

  // Field widths
  localparam int LINE_W   = 9;
  localparam int HORIZ_W  = 8;
  localparam int TRIG_W   = 10;
  localparam int STEP_W   = 16;
  localparam int COORD_W  = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register reset values
  localparam logic [HORIZ_W-1:0] HORIZON_RST = 8'd60;
  localparam logic [TRIG_W-1:0]  COSINE_RST  = 10'd256;
  localparam logic [TRIG_W-1:0]  SINE_RST    = 10'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HORIZON  = 3'd0,
    CFG_COSINE   = 3'd1,
    CFG_SINE     = 3'd2,
    CFG_CAMERA_X = 3'd3,
    CFG_CAMERA_Z = 3'd4
  } pfla_cfg_e;

  // Control that travels with each item down the pipeline
  typedef struct packed {
    logic valid;
    logic blank;
  } pfla_ctl_t;

endpackage

// ----- src/pfla_div.sv -----
module pfla_div #(
  parameter int FRACTION_BITS = pfla_pkg::FRACTION_BITS_DEF
) (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  logic                                                adv_i,
  input  pfla_pkg::pfla_ctl_t                                 ctl_i,
  input  logic [pfla_pkg::LINE_W-1:0]                         row_i,
  output pfla_pkg::pfla_ctl_t                                 ctl_o,
  output logic [pfla_pkg::DISTANCE_BITS+FRACTION_BITS-1:0]    quot_o
);

  localparam int DW   = pfla_pkg::DISTANCE_BITS + FRACTION_BITS;
  localparam int RW   = pfla_pkg::LINE_W;
  localparam int SPS  = pfla_pkg::DIV_STEPS_PER_STAGE;
  localparam int NSTG = (DW + SPS - 1) / SPS;
  localparam logic [DW-1:0] DIVIDEND = DW'(pfla_pkg::FLOOR_DISTANCE << FRACTION_BITS);

  pfla_pkg::pfla_ctl_t stg_ctl [NSTG+1];
  logic [RW-1:0]       stg_row [NSTG+1];
  logic [RW-1:0]       stg_rem [NSTG+1];
  logic [DW-1:0]       stg_quo [NSTG+1];

  assign stg_ctl[0] = ctl_i;
  assign stg_row[0] = row_i;
  assign stg_rem[0] = '0;
  assign stg_quo[0] = '0;

  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    pfla_pkg::pfla_ctl_t ctl_q;
    logic [RW-1:0]       row_q;
    logic [RW-1:0]       rem_q, rem_d;
    logic [DW-1:0]       quo_q, quo_d;

    // Resolve SPS quotient bits, MSB first
    always_comb begin
      logic [RW:0] trial;
      trial = '0;
      rem_d = stg_rem[s];
      quo_d = stg_quo[s];
      for (int j = 0; j < SPS; j++) begin
        if (s * SPS + j < DW) begin
          trial = {rem_d, DIVIDEND[DW-1-(s*SPS+j)]};
          if (trial >= {1'b0, stg_row[s]}) begin
            rem_d = RW'(trial - {1'b0, stg_row[s]});
            quo_d = {quo_d[DW-2:0], 1'b1};
          end else begin
            rem_d = trial[RW-1:0];
            quo_d = {quo_d[DW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q <= '0;
      end else if (adv_i) begin
        ctl_q <= stg_ctl[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        row_q <= stg_row[s];
        rem_q <= rem_d;
        quo_q <= quo_d;
      end
    end

    assign stg_ctl[s+1] = ctl_q;
    assign stg_row[s+1] = row_q;
    assign stg_rem[s+1] = rem_q;
    assign stg_quo[s+1] = quo_q;
  end

  assign ctl_o  = stg_ctl[NSTG];
  assign quot_o = stg_quo[NSTG];

endmodule

// ----- src/pfla_rot.sv -----
module pfla_rot #(
  parameter int FRACTION_BITS = pfla_pkg::FRACTION_BITS_DEF
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             adv_i,
  input  pfla_pkg::pfla_ctl_t                              ctl_i,
  input  logic [pfla_pkg::DISTANCE_BITS+FRACTION_BITS-1:0] scale_i,
  input  logic signed [pfla_pkg::TRIG_W-1:0]               cos_i,
  input  logic signed [pfla_pkg::TRIG_W-1:0]               sin_i,
  output pfla_pkg::pfla_ctl_t                              ctl_o,
  output logic [pfla_pkg::STEP_W-1:0]                      c_o,
  output logic [pfla_pkg::STEP_W-1:0]                      s_o,
  output logic [pfla_pkg::COORD_W-1:0]                     dx_o,
  output logic [pfla_pkg::COORD_W-1:0]                     dy_o
);

  localparam int DW = pfla_pkg::DISTANCE_BITS + FRACTION_BITS;
  localparam int PW = DW + 1 + pfla_pkg::TRIG_W;
  localparam int CW = pfla_pkg::COORD_W;
  localparam int EW = (PW + 8 > CW) ? PW + 8 : CW;

  // Multiply stage
  pfla_pkg::pfla_ctl_t ctl_m_q;
  logic signed [PW-1:0] prod_c_q, prod_s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_m_q <= '0;
    end else if (adv_i) begin
      ctl_m_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_c_q <= $signed({1'b0, scale_i}) * cos_i;
      prod_s_q <= $signed({1'b0, scale_i}) * sin_i;
    end
  end

  // Scale back, form texel offsets
  logic signed [PW-1:0] c_full, s_full;
  logic signed [EW-1:0] cm, sm;
  logic [CW-1:0]        dx_d, dy_d;

  always_comb begin
    c_full = prod_c_q >>> FRACTION_BITS;
    s_full = prod_s_q >>> FRACTION_BITS;
    cm     = (EW'(c_full) * EW'(pfla_pkg::TEXEL_CENTER)) >>> FRACTION_BITS;
    sm     = (EW'(s_full) * EW'(pfla_pkg::TEXEL_CENTER)) >>> FRACTION_BITS;
    dx_d   = CW'(pfla_pkg::TEXEL_CENTER) - cm[CW-1:0] + sm[CW-1:0];
    dy_d   = CW'(pfla_pkg::TEXEL_CENTER) - sm[CW-1:0] - cm[CW-1:0];
  end

  pfla_pkg::pfla_ctl_t ctl_t_q;
  logic [pfla_pkg::STEP_W-1:0] c_q, s_q;
  logic [CW-1:0]               dx_q, dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_t_q <= '0;
    end else if (adv_i) begin
      ctl_t_q <= ctl_m_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      c_q  <= c_full[pfla_pkg::STEP_W-1:0];
      s_q  <= s_full[pfla_pkg::STEP_W-1:0];
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
  end

  assign ctl_o = ctl_t_q;
  assign c_o   = c_q;
  assign s_o   = s_q;
  assign dx_o  = dx_q;
  assign dy_o  = dy_q;

endmodule

// ----- src/perspective_floor_line_affine.sv -----
// Channel  | Handshake                    | Payload
// ---------+------------------------------+-------------------------------------------
// input    | in_valid_i / in_stall_o      | scan_line_i
// output   | out_valid_o / out_stall_i    | step_xx_o step_xy_o step_yx_o step_yy_o
//          |                              | origin_x_o origin_y_o
// config   | cfg_we_i                     | cfg_index_i cfg_data_i
//
// One item per cycle while the output is not stalled. Pipeline: input register,
// the divider stages resolving four quotient bits each, multiply, offset,
// output register.
// Reset clears valid bits and loads register defaults; no clearing pass.
// A stalled output holds the whole pipeline; in_stall_o follows out_stall_i
// while an item waits at the output.
module perspective_floor_line_affine #(
  parameter int FRACTION_BITS = pfla_pkg::FRACTION_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic [pfla_pkg::LINE_W-1:0]             scan_line_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [pfla_pkg::STEP_W-1:0]      step_xx_o,
  output logic signed [pfla_pkg::STEP_W-1:0]      step_xy_o,
  output logic signed [pfla_pkg::STEP_W-1:0]      step_yx_o,
  output logic signed [pfla_pkg::STEP_W-1:0]      step_yy_o,
  output logic signed [pfla_pkg::COORD_W-1:0]     origin_x_o,
  output logic signed [pfla_pkg::COORD_W-1:0]     origin_y_o,
  input  logic                                    cfg_we_i,
  input  logic [pfla_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [pfla_pkg::CFG_DATA_W-1:0]         cfg_data_i
);

  localparam int DW = pfla_pkg::DISTANCE_BITS + FRACTION_BITS;
  localparam int CW = pfla_pkg::COORD_W;
  localparam int SW = pfla_pkg::STEP_W;
  localparam logic [CW-1:0] FRAC_MASK = CW'((64'd1 << FRACTION_BITS) - 64'd1);

  // Configuration registers
  logic [pfla_pkg::HORIZ_W-1:0]       horizon_q;
  logic signed [pfla_pkg::TRIG_W-1:0] cosine_q, sine_q;
  logic [CW-1:0]                      cam_x_q, cam_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      horizon_q <= pfla_pkg::HORIZON_RST;
      cosine_q  <= pfla_pkg::COSINE_RST;
      sine_q    <= pfla_pkg::SINE_RST;
      cam_x_q   <= '0;
      cam_z_q   <= '0;
    end else if (cfg_we_i) begin
      case (pfla_pkg::pfla_cfg_e'(cfg_index_i))
        pfla_pkg::CFG_HORIZON:  horizon_q <= cfg_data_i[pfla_pkg::HORIZ_W-1:0];
        pfla_pkg::CFG_COSINE:   cosine_q  <= cfg_data_i[pfla_pkg::TRIG_W-1:0];
        pfla_pkg::CFG_SINE:     sine_q    <= cfg_data_i[pfla_pkg::TRIG_W-1:0];
        pfla_pkg::CFG_CAMERA_X: cam_x_q   <= cfg_data_i[CW-1:0];
        pfla_pkg::CFG_CAMERA_Z: cam_z_q   <= cfg_data_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // Whole pipeline advances unless a result waits at the output
  pfla_pkg::pfla_ctl_t out_ctl_q;
  logic adv;

  assign adv        = !(out_ctl_q.valid && out_stall_i);
  assign in_stall_o = !adv;

  // Input stage: row below horizon
  pfla_pkg::pfla_ctl_t in_ctl_q, in_ctl_d;
  logic [pfla_pkg::LINE_W-1:0] row_q, row_d;

  always_comb begin
    in_ctl_d.valid = in_valid_i;
    in_ctl_d.blank = (scan_line_i <= {1'b0, horizon_q});
    row_d          = scan_line_i - {1'b0, horizon_q};
    if (in_ctl_d.blank) begin
      row_d = pfla_pkg::LINE_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ctl_q <= '0;
    end else if (adv) begin
      in_ctl_q <= in_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      row_q <= row_d;
    end
  end

  pfla_pkg::pfla_ctl_t div_ctl;
  logic [DW-1:0]       scale;

  pfla_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .ctl_i  (in_ctl_q),
    .row_i  (row_q),
    .ctl_o  (div_ctl),
    .quot_o (scale)
  );

  pfla_pkg::pfla_ctl_t rot_ctl;
  logic [SW-1:0]       c_val, s_val;
  logic [CW-1:0]       dx, dy;

  pfla_rot #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_rot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .ctl_i   (div_ctl),
    .scale_i (scale),
    .cos_i   (cosine_q),
    .sin_i   (sine_q),
    .ctl_o   (rot_ctl),
    .c_o     (c_val),
    .s_o     (s_val),
    .dx_o    (dx),
    .dy_o    (dy)
  );

  // Output register: add camera floor, zero blank lines
  logic [SW-1:0] xx_q, xy_q, yx_q, yy_q, xx_d, xy_d, yx_d, yy_d;
  logic [CW-1:0] ox_q, oy_q, ox_d, oy_d;

  always_comb begin
    xx_d = c_val;
    xy_d = SW'(0) - s_val;
    yx_d = s_val;
    yy_d = c_val;
    ox_d = (cam_x_q & ~FRAC_MASK) + dx;
    oy_d = (cam_z_q & ~FRAC_MASK) + dy;
    if (rot_ctl.blank) begin
      xx_d = '0;
      xy_d = '0;
      yx_d = '0;
      yy_d = '0;
      ox_d = '0;
      oy_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ctl_q <= '0;
    end else if (adv) begin
      out_ctl_q <= rot_ctl;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      xx_q <= xx_d;
      xy_q <= xy_d;
      yx_q <= yx_d;
      yy_q <= yy_d;
      ox_q <= ox_d;
      oy_q <= oy_d;
    end
  end

  assign out_valid_o = out_ctl_q.valid;
  assign step_xx_o   = xx_q;
  assign step_xy_o   = xy_q;
  assign step_yx_o   = yx_q;
  assign step_yy_o   = yy_q;
  assign origin_x_o  = ox_q;
  assign origin_y_o  = oy_q;

endmodule

// ----- dv/perspective_floor_line_affine_tb.sv -----
module perspective_floor_line_affine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = pfla_pkg::FRACTION_BITS_DEF;
  localparam logic [pfla_pkg::COORD_W-1:0] FRAC_MASK = (32'd1 << FRAC) - 32'd1;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES = 24;
  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 150;

  typedef struct packed {
    logic signed [pfla_pkg::STEP_W-1:0]  xx;
    logic signed [pfla_pkg::STEP_W-1:0]  xy;
    logic signed [pfla_pkg::STEP_W-1:0]  yx;
    logic signed [pfla_pkg::STEP_W-1:0]  yy;
    logic signed [pfla_pkg::COORD_W-1:0] ox;
    logic signed [pfla_pkg::COORD_W-1:0] oy;
  } floor_affine_t;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                in_valid_i = 1'b0;
  logic                                in_stall_o;
  logic [pfla_pkg::LINE_W-1:0]         scan_line_i = '0;
  logic                                out_valid_o;
  logic                                out_stall_i = 1'b0;
  logic signed [pfla_pkg::STEP_W-1:0]  step_xx_o;
  logic signed [pfla_pkg::STEP_W-1:0]  step_xy_o;
  logic signed [pfla_pkg::STEP_W-1:0]  step_yx_o;
  logic signed [pfla_pkg::STEP_W-1:0]  step_yy_o;
  logic signed [pfla_pkg::COORD_W-1:0] origin_x_o;
  logic signed [pfla_pkg::COORD_W-1:0] origin_y_o;
  logic                                cfg_we_i = 1'b0;
  logic [pfla_pkg::CFG_IDX_W-1:0]      cfg_index_i = '0;
  logic [pfla_pkg::CFG_DATA_W-1:0]     cfg_data_i = '0;

  // Shadow copy of the block's registers
  logic [pfla_pkg::HORIZ_W-1:0]       horizon_q = pfla_pkg::HORIZON_RST;
  logic signed [pfla_pkg::TRIG_W-1:0] cosine_q = pfla_pkg::COSINE_RST;
  logic signed [pfla_pkg::TRIG_W-1:0] sine_q = pfla_pkg::SINE_RST;
  logic [pfla_pkg::COORD_W-1:0]       camera_x_q = '0;
  logic [pfla_pkg::COORD_W-1:0]       camera_z_q = '0;

  floor_affine_t affine_due[$];
  int  mismatches = 0;
  int  quiet_cycles = 0;
  bit  sender_gaps = 1'b0;
  bit  receiver_stalls = 1'b0;
  bit  hold_request = 1'b0;
  logic [pfla_pkg::LINE_W-1:0] sweep_line = '0;

  perspective_floor_line_affine uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .scan_line_i (scan_line_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .step_xx_o   (step_xx_o),
    .step_xy_o   (step_xy_o),
    .step_yx_o   (step_yx_o),
    .step_yy_o   (step_yy_o),
    .origin_x_o  (origin_x_o),
    .origin_y_o  (origin_y_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic floor_affine_t predict_affine(
    input logic [pfla_pkg::LINE_W-1:0] line
  );
    floor_affine_t r;
    longint row, scale, c, s, cm, sm;
    r = '0;
    row = longint'(line) - longint'(horizon_q);
    if (row > 0) begin
      scale = (longint'(pfla_pkg::FLOOR_DISTANCE) << FRAC) / row;
      c = (scale * longint'(cosine_q)) >>> FRAC;
      s = (scale * longint'(sine_q)) >>> FRAC;
      cm = (c * pfla_pkg::TEXEL_CENTER) >>> FRAC;
      sm = (s * pfla_pkg::TEXEL_CENTER) >>> FRAC;
      r.xx = pfla_pkg::STEP_W'(c);
      r.xy = pfla_pkg::STEP_W'(-s);
      r.yx = pfla_pkg::STEP_W'(s);
      r.yy = pfla_pkg::STEP_W'(c);
      r.ox = (camera_x_q & ~FRAC_MASK) +
             pfla_pkg::COORD_W'(pfla_pkg::TEXEL_CENTER - cm + sm);
      r.oy = (camera_z_q & ~FRAC_MASK) +
             pfla_pkg::COORD_W'(pfla_pkg::TEXEL_CENTER - sm - cm);
    end
    return r;
  endfunction

  // Called at a falling edge; returns at a falling edge with valid still high
  task automatic send_line(input logic [pfla_pkg::LINE_W-1:0] line);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    scan_line_i <= line;
    do @(posedge clk_i); while (in_stall_o);
    affine_due.push_back(predict_affine(line));
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every item has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (affine_due.size() != 0);
  endtask

  task automatic write_reg(input logic [pfla_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pfla_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      pfla_pkg::CFG_HORIZON:  horizon_q  = data[pfla_pkg::HORIZ_W-1:0];
      pfla_pkg::CFG_COSINE:   cosine_q   = data[pfla_pkg::TRIG_W-1:0];
      pfla_pkg::CFG_SINE:     sine_q     = data[pfla_pkg::TRIG_W-1:0];
      pfla_pkg::CFG_CAMERA_X: camera_x_q = data;
      pfla_pkg::CFG_CAMERA_Z: camera_z_q = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [pfla_pkg::CFG_DATA_W-1:0] random_trig();
    logic [pfla_pkg::CFG_DATA_W-1:0] d;
    d = $urandom;
    case ($urandom_range(0, 7))
      0: d[pfla_pkg::TRIG_W-1:0] = pfla_pkg::TRIG_W'(-256);
      1: d[pfla_pkg::TRIG_W-1:0] = pfla_pkg::TRIG_W'(256);
      2: d[pfla_pkg::TRIG_W-1:0] = pfla_pkg::TRIG_W'(-512);
      3: d[pfla_pkg::TRIG_W-1:0] = pfla_pkg::TRIG_W'(511);
      default: d[pfla_pkg::TRIG_W-1:0] = pfla_pkg::TRIG_W'($urandom_range(0, 512) - 256);
    endcase
    return d;
  endfunction

  function automatic logic [pfla_pkg::CFG_DATA_W-1:0] random_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic check_field(input string name, input longint expv, input longint actv);
    if (expv != actv) begin
      $display("%0t %s expected %0d actual %0d", $time, name, expv, actv);
      mismatches++;
    end
  endtask

  // Compare each output item with the oldest prediction
  always @(posedge clk_i) begin
    floor_affine_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (affine_due.size() == 0) begin
        $display("%0t unexpected item expected none actual xx=%0d ox=%0d",
                 $time, step_xx_o, origin_x_o);
        mismatches++;
      end else begin
        want = affine_due.pop_front();
        check_field("step_xx", want.xx, step_xx_o);
        check_field("step_xy", want.xy, step_xy_o);
        check_field("step_yx", want.yx, step_yx_o);
        check_field("step_yy", want.yy, step_yy_o);
        check_field("origin_x", want.ox, origin_x_o);
        check_field("origin_y", want.oy, origin_y_o);
      end
    end
  end

  // Receiver: random stall bursts, or one long hold when requested
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        out_stall_i <= 1'b1;
        n = HOLD_CYCLES;
        hold_request = 1'b0;
      end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        n = $urandom_range(1, 8);
      end else begin
        out_stall_i <= 1'b0;
        n = $urandom_range(1, 8);
      end
      repeat (n - 1) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic test_directed();
    // reset defaults: blank lines, the horizon itself, first line below it
    send_line(9'd0);
    send_line(9'd59);
    send_line(9'd60);
    send_line(9'd61);
    send_line(9'd62);
    send_line(9'd100);
    send_line(9'd220);
    send_line(9'd511);
    wait_drained();
    // out-of-range trig and camera extremes: steps and origins wrap
    write_reg(pfla_pkg::CFG_HORIZON, 32'd0);
    write_reg(pfla_pkg::CFG_COSINE, 32'(-512));
    write_reg(pfla_pkg::CFG_SINE, 32'd511);
    write_reg(pfla_pkg::CFG_CAMERA_X, 32'h7FFF_FFFF);
    write_reg(pfla_pkg::CFG_CAMERA_Z, 32'h8000_0000);
    send_line(9'd0);
    send_line(9'd1);
    send_line(9'd2);
    send_line(9'd255);
    send_line(9'd511);
    wait_drained();
    write_reg(pfla_pkg::CFG_HORIZON, 32'hFFFF_FFFF);
    write_reg(pfla_pkg::CFG_COSINE, 32'(-256));
    write_reg(pfla_pkg::CFG_SINE, 32'd256);
    write_reg(pfla_pkg::CFG_CAMERA_X, 32'hFFFF_FF80);
    write_reg(pfla_pkg::CFG_CAMERA_Z, 32'h0000_00FF);
    // writes to unused indexes must leave every register alone
    for (int i = int'(pfla_pkg::CFG_CAMERA_Z) + 1; i < 2 ** pfla_pkg::CFG_IDX_W; i++) begin
      write_reg(pfla_pkg::CFG_IDX_W'(i), 32'hFFFF_FFFF);
    end
    send_line(9'd254);
    send_line(9'd255);
    send_line(9'd256);
    send_line(9'd300);
    send_line(9'd511);
    wait_drained();
  endtask

  task automatic test_backpressure();
    sender_gaps = 1'b0;
    receiver_stalls = 1'b1;
    hold_request = 1'b1;
    // keep offering items so the pipeline fills behind the held output
    repeat (60) send_line(pfla_pkg::LINE_W'($urandom));
    wait_drained();
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < PHASES; p++) begin
      write_reg(pfla_pkg::CFG_HORIZON, ($urandom_range(0, 3) == 0) ?
                ($urandom_range(0, 1) ? 32'd255 : 32'd0) : $urandom);
      write_reg(pfla_pkg::CFG_COSINE, random_trig());
      write_reg(pfla_pkg::CFG_SINE, random_trig());
      write_reg(pfla_pkg::CFG_CAMERA_X, random_coord());
      write_reg(pfla_pkg::CFG_CAMERA_Z, random_coord());
      // quiet handshakes in the final phase
      sender_gaps = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
      receiver_stalls = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
      sweep_line = pfla_pkg::LINE_W'($urandom);
      repeat (ITEMS_PER_PHASE) begin
        // mix frame-like line sweeps with scattered lines
        if ($urandom_range(0, 1)) begin
          sweep_line = sweep_line + 1'b1;
          send_line(sweep_line);
        end else begin
          send_line(pfla_pkg::LINE_W'($urandom));
        end
      end
      wait_drained();
    end
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_backpressure();
    test_random_phases();
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
